### hdl/tea_pkg.sv
// Shared types and constants for the TEA block cipher unit.
`default_nettype none

package tea_pkg;

    // Word and field widths.
    localparam int WORD_W   = 32;
    localparam int ROUND_W  = 8;
    localparam int CNT_W    = ROUND_W + 1;
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;

    // Key schedule constant and register reset values.
    localparam logic [WORD_W-1:0]  TEA_DELTA    = 32'h9e3779b9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 8'd32;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_ROUNDS = 3'd4;

    // Request opcodes.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // The four key words as one bundle.
    typedef struct packed {
        logic [WORD_W-1:0] k3;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k0;
    } t_key;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request and seed the running sum
        logic step;      // apply one half-round
        logic phase_b;   // second half-round of the current cycle
        logic out_load;  // move the finished block into the output register
    } t_dp_cmd;

endpackage : tea_pkg

`default_nettype wire

### hdl/tea_regs.sv
// Configuration registers of the TEA unit behind an APB-style port.
`default_nettype none

module tea_regs
    import tea_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CFG_AW-1:0]   paddr,
    input  wire logic [CFG_DW-1:0]   pwdata,
    output logic      [CFG_DW-1:0]   prdata,
    output logic                     pready,
    output t_key                     o_key,
    output logic      [ROUND_W-1:0]  o_round_count
);

    t_key               r_key;
    logic [ROUND_W-1:0] r_rounds;
    logic [2:0]         w_index;
    logic               w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_rounds <= ROUNDS_RESET;
        end else if (w_write) begin
            case (w_index)
                REG_KEY0:   r_key.k0 <= pwdata;
                REG_KEY1:   r_key.k1 <= pwdata;
                REG_KEY2:   r_key.k2 <= pwdata;
                REG_KEY3:   r_key.k3 <= pwdata;
                REG_ROUNDS: r_rounds <= pwdata[ROUND_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (w_index)
            REG_KEY0:   prdata = r_key.k0;
            REG_KEY1:   prdata = r_key.k1;
            REG_KEY2:   prdata = r_key.k2;
            REG_KEY3:   prdata = r_key.k3;
            REG_ROUNDS: prdata = {{(CFG_DW-ROUND_W){1'b0}}, r_rounds};
            default:    prdata = '0;
        endcase
    end

    assign o_key         = r_key;
    assign o_round_count = r_rounds;

endmodule : tea_regs

`default_nettype wire

### hdl/tea_dp.sv
// Datapath of the TEA unit: block words, running sum, half-round logic, output register.
`default_nettype none

module tea_dp
    import tea_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_dp_cmd             i_cmd,
    input  wire t_key                i_key,
    input  wire logic [ROUND_W-1:0]  i_round_count,
    input  wire logic                i_opcode,
    input  wire logic [WORD_W-1:0]   i_left_word,
    input  wire logic [WORD_W-1:0]   i_right_word,
    output logic      [WORD_W-1:0]   o_left_result,
    output logic      [WORD_W-1:0]   o_right_result
);

    logic [WORD_W-1:0] r_v0, r_v1, r_sum;
    logic              r_dec;
    logic [WORD_W-1:0] r_out0, r_out1;

    logic              w_sel;
    logic [WORD_W-1:0] w_x, w_target, w_ka, w_kb, w_mix, w_upd;
    logic [WORD_W-1:0] w_dec_sum;

    // Decryption seeds the sum with delta times the cycle count, modulo 2^32.
    assign w_dec_sum = TEA_DELTA * {{(WORD_W-ROUND_W){1'b0}}, i_round_count};

    // The half-round in use: the low key pair updates v0 from v1, the high pair v1 from v0.
    // Decryption runs the half-rounds in reverse order.
    assign w_sel    = i_cmd.phase_b ^ r_dec;
    assign w_x      = w_sel ? r_v0 : r_v1;
    assign w_target = w_sel ? r_v1 : r_v0;
    assign w_ka     = w_sel ? i_key.k2 : i_key.k0;
    assign w_kb     = w_sel ? i_key.k3 : i_key.k1;

    assign w_mix = ((w_x << 4) + w_ka) ^ (w_x + r_sum) ^ ((w_x >> 5) + w_kb);
    assign w_upd = r_dec ? (w_target - w_mix) : (w_target + w_mix);

    // Block words and running sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v0  <= i_left_word;
            r_v1  <= i_right_word;
            r_dec <= i_opcode;
            r_sum <= (i_opcode == OP_DECRYPT) ? w_dec_sum : TEA_DELTA;
        end else if (i_cmd.step) begin
            if (w_sel) begin
                r_v1 <= w_upd;
            end else begin
                r_v0 <= w_upd;
            end
            // The sum moves on after the second half-round of each cycle.
            if (i_cmd.phase_b) begin
                r_sum <= r_dec ? (r_sum - TEA_DELTA) : (r_sum + TEA_DELTA);
            end
        end
    end

    // Output register, so a new request can run while a result waits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out0 <= r_v0;
            r_out1 <= r_v1;
        end
    end

    assign o_left_result  = r_out0;
    assign o_right_result = r_out1;

endmodule : tea_dp

`default_nettype wire

### hdl/tea_ctrl.sv
// Controller of the TEA unit: request handshake, half-round counter, output valid.
`default_nettype none

module tea_ctrl
    import tea_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [ROUND_W-1:0]  i_round_count,
    output t_dp_cmd                  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept, w_slot_free, w_last;

    assign w_accept    = (r_state == ST_IDLE) && i_in_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last      = (r_cnt == CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_round_count == '0) ? ST_WAIT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.phase_b    = r_cnt[0];
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
            end
            ST_WAIT: begin
                o_cmd.out_load = w_slot_free;
            end
            default: ;
        endcase
    end

    // Half-round counter: two per TEA cycle, counting down.
    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            n_cnt = {i_round_count, 1'b0};
        end else if (r_state == ST_RUN) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule : tea_ctrl

`default_nettype wire

### hdl/tea_block_cipher_unit.sv
// Top level of the TEA block cipher unit.
//
// Requests arrive on the s_axis channel: tdata carries the two block words and
// tuser the opcode (0 encrypt, 1 decrypt). Results leave on the m_axis channel
// with the two processed words in tdata. Keys and the cycle count sit in the
// APB registers; the user writes them only while the unit is idle, which the
// unit does not enforce. One request is in work at a time. Each TEA cycle is
// two half-rounds, run one after the other through the shared add/xor unit.
// After the last half-round the block moves into the output register, which
// raises m_axis_tvalid, and the unit returns to idle to accept the next request.
// A count of zero passes the block through unchanged into the output register.
// The output register holds one result, so a new request is taken and worked
// on while the receiver stalls; the unit then waits with the next finished
// block until the output register frees up.
// Reset clears the keys to zero, sets the cycle count to 32 and leaves no
// result pending.
`default_nettype none

module tea_block_cipher_unit
    import tea_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request channel.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [63:0]         s_axis_tdata,   // [31:0] left_word, [63:32] right_word
    input  wire logic                s_axis_tuser,   // [0] opcode
    // Result channel.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [63:0]         m_axis_tdata,   // [31:0] left_result, [63:32] right_result
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CFG_AW-1:0]   paddr,
    input  wire logic [CFG_DW-1:0]   pwdata,
    output logic      [CFG_DW-1:0]   prdata,
    output logic                     pready
);

    t_key               w_key;
    logic [ROUND_W-1:0] w_round_count;
    t_dp_cmd            w_cmd;
    logic [WORD_W-1:0]  w_left_result, w_right_result;

    tea_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_key         (w_key),
        .o_round_count (w_round_count)
    );

    tea_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_round_count (w_round_count),
        .o_cmd         (w_cmd)
    );

    tea_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_key          (w_key),
        .i_round_count  (w_round_count),
        .i_opcode       (s_axis_tuser),
        .i_left_word    (s_axis_tdata[31:0]),
        .i_right_word   (s_axis_tdata[63:32]),
        .o_left_result  (w_left_result),
        .o_right_result (w_right_result)
    );

    assign m_axis_tdata = {w_right_result, w_left_result};

endmodule : tea_block_cipher_unit

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the TEA block cipher unit: directed probes, then random phases.
module tb_top;
    import tea_pkg::*;

    // Receiver ready patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    // One row of the directed probes: the register setting it needs and the request.
    typedef struct {
        logic [ROUND_W-1:0]  rounds;
        logic [127:0]        key;        // {key_word_3, key_word_2, key_word_1, key_word_0}
        logic                op;
        logic [WORD_W-1:0]   lw;
        logic [WORD_W-1:0]   rw;
        bit                  typed;      // expected block given in the row
        logic [WORD_W-1:0]   want_lw;
        logic [WORD_W-1:0]   want_rw;
    } t_probe;

    localparam int PROBE_COUNT = 18;
    localparam logic [127:0] KEY_ONES   = {128{1'b1}};
    localparam logic [127:0] KEY_MIXED  = 128'hccddeeff_8899aabb_44556677_00112233;
    localparam logic [127:0] KEY_STRIPE = 128'haaaaaaaa_55555555_aaaaaaaa_55555555;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;     // [31:0] left_word, [63:32] right_word
    logic                 s_axis_tuser = 1'b0;   // [0] opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;          // [31:0] left_result, [63:32] right_result
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [CFG_AW-1:0]    paddr = '0;
    logic [CFG_DW-1:0]    pwdata = '0;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    // Register copy used by the predictor; starts at the reset values.
    logic [WORD_W-1:0]    cfg_key [4] = '{default: '0};
    logic [ROUND_W-1:0]   cfg_rounds = ROUNDS_RESET;

    // Blocks still owed by the unit, {right, left}, oldest first.
    logic [63:0]          expected_blocks [$];

    int                   error_count = 0;
    int                   requests_sent = 0;
    int                   results_checked = 0;
    int                   settings_applied = 0;
    int                   burst_left = 0;
    t_rx_mode             rx_mode = RX_ALWAYS;
    logic [7:0]           rx_phase = '0;
    logic                 rx_hold = 1'b0;
    bit                   hold_go = 1'b0;

    t_probe probe_rows [PROBE_COUNT] = '{
        // Reset setting: zero key, round count 32.
        '{8'd32, 128'h0, OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{8'd32, 128'h0, OP_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{8'd32, 128'h0, OP_ENCRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{8'd32, 128'h0, OP_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        // Zero cycles pass the block through in both directions.
        '{8'd0, KEY_ONES, OP_ENCRYPT, 32'h00000000, 32'hffffffff, 1'b1,
          32'h00000000, 32'hffffffff},
        '{8'd0, KEY_ONES, OP_DECRYPT, 32'hffffffff, 32'h00000000, 1'b1,
          32'hffffffff, 32'h00000000},
        '{8'd0, KEY_ONES, OP_ENCRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b1,
          32'ha5a5a5a5, 32'h5a5a5a5a},
        '{8'd0, KEY_ONES, OP_DECRYPT, 32'h12345678, 32'h9abcdef0, 1'b1,
          32'h12345678, 32'h9abcdef0},
        // Single cycle.
        '{8'd1, KEY_ONES, OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{8'd1, KEY_ONES, OP_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{8'd1, KEY_MIXED, OP_ENCRYPT, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
        // Largest cycle count; its decrypt sum wraps.
        '{8'd255, KEY_ONES, OP_ENCRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{8'd255, KEY_ONES, OP_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{8'd255, 128'h0, OP_ENCRYPT, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0},
        '{8'd32, KEY_MIXED, OP_ENCRYPT, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
        '{8'd32, KEY_MIXED, OP_DECRYPT, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0, 32'h0},
        '{8'd16, KEY_STRIPE, OP_ENCRYPT, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0, 32'h0, 32'h0},
        '{8'd16, KEY_STRIPE, OP_DECRYPT, 32'hf0f0f0f0, 32'h0f0f0f0f, 1'b0, 32'h0, 32'h0}
    };

    tea_block_cipher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Round function shared by both half-rounds.
    function automatic logic [WORD_W-1:0] half_round_mix(input logic [WORD_W-1:0] v,
            input logic [WORD_W-1:0] sum, input logic [WORD_W-1:0] ka,
            input logic [WORD_W-1:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // Processed block under the current register copy, as {right, left}.
    function automatic logic [63:0] tea_cipher_block(input logic op,
            input logic [WORD_W-1:0] lw, input logic [WORD_W-1:0] rw);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        v0 = lw;
        v1 = rw;
        if (op == OP_ENCRYPT) begin
            sum = '0;
            for (int n = 0; n < int'(cfg_rounds); n++) begin
                sum = sum + TEA_DELTA;
                v0 = v0 + half_round_mix(v1, sum, cfg_key[0], cfg_key[1]);
                v1 = v1 + half_round_mix(v0, sum, cfg_key[2], cfg_key[3]);
            end
        end else begin
            // The starting sum wraps modulo 2^32.
            sum = TEA_DELTA * {24'd0, cfg_rounds};
            for (int n = 0; n < int'(cfg_rounds); n++) begin
                v1 = v1 - half_round_mix(v0, sum, cfg_key[2], cfg_key[3]);
                v0 = v0 - half_round_mix(v1, sum, cfg_key[0], cfg_key[1]);
                sum = sum - TEA_DELTA;
            end
        end
        return {v1, v0};
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Compares one delivered block with the oldest one owed.
    task automatic check_block(input logic [63:0] got);
        logic [63:0] want;
        if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with no request pending", got));
            return;
        end
        want = expected_blocks.pop_front();
        results_checked++;
        if (got[31:0] !== want[31:0])
            report_mismatch($sformatf("left_result %h, predicted %h", got[31:0], want[31:0]));
        if (got[63:32] !== want[63:32])
            report_mismatch($sformatf("right_result %h, predicted %h", got[63:32],
                want[63:32]));
    endtask

    // Result side: check every accepted result and pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_block(m_axis_tdata);
            rx_phase <= rx_phase + 8'd1;
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 1) == 0);
                    RX_PATTERN: m_axis_tready <= (rx_phase[3:0] < 4'd5);
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Long receiver hold-off so that the unit fills and stalls its request side.
    initial begin
        wait (hold_go);
        repeat ($urandom_range(20, 60)) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Offers one request and waits for its acceptance, then maybe pauses.
    task automatic send_request(input logic op, input logic [WORD_W-1:0] lw,
            input logic [WORD_W-1:0] rw, input logic [63:0] want);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {rw, lw};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(want);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic finish_pending();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One APB transfer, after which psel and penable drop back to idle.
    task automatic apb_transfer(input logic write, input logic [2:0] idx,
            input logic [CFG_DW-1:0] value, output logic [CFG_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes a register, tracks it in the predictor and reads it back if it exists.
    task automatic write_register(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
        logic [CFG_DW-1:0] rdata;
        apb_transfer(1'b1, idx, value, rdata);
        case (idx)
            REG_KEY0:   cfg_key[0] = value;
            REG_KEY1:   cfg_key[1] = value;
            REG_KEY2:   cfg_key[2] = value;
            REG_KEY3:   cfg_key[3] = value;
            REG_ROUNDS: cfg_rounds = value[ROUND_W-1:0];
            default:    ;
        endcase
        if (idx <= REG_ROUNDS) begin
            apb_transfer(1'b0, idx, '0, rdata);
            if (idx == REG_ROUNDS) begin
                if (rdata[ROUND_W-1:0] !== cfg_rounds)
                    report_mismatch($sformatf("round_count reads %h, written %h",
                        rdata[ROUND_W-1:0], cfg_rounds));
            end else if (rdata !== cfg_key[idx]) begin
                report_mismatch($sformatf("key word %0d reads %h, written %h", idx, rdata,
                    cfg_key[idx]));
            end
        end
    endtask

    // Brings the registers to a setting; the unit is drained first unless nothing changes.
    task automatic apply_setting(input logic [ROUND_W-1:0] rounds, input logic [127:0] key,
            input bit every_reg);
        if (!every_reg && rounds == cfg_rounds &&
                key == {cfg_key[3], cfg_key[2], cfg_key[1], cfg_key[0]})
            return;
        finish_pending();
        for (int w = 0; w < 4; w++)
            if (every_reg || key[32*w +: 32] != cfg_key[w])
                write_register(REG_KEY0 + 3'(w), key[32*w +: 32]);
        // Bits above the cycle count are set at random and must be ignored.
        if (every_reg || rounds != cfg_rounds)
            write_register(REG_ROUNDS, {24'($urandom), rounds});
        settings_applied++;
    endtask

    // Stimulus: directed probes, then random phases under several settings.
    initial begin
        logic [63:0]        want;
        logic [63:0]        last_block;
        logic               last_op;
        bit                 have_last;
        logic [127:0]       key;
        logic [ROUND_W-1:0] rounds;
        logic               op;
        logic [WORD_W-1:0]  lw;
        logic [WORD_W-1:0]  rw;
        int                 count;
        t_rx_mode           mode;

        have_last = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed probes; the first rows run on the reset setting.
        foreach (probe_rows[n]) begin
            apply_setting(probe_rows[n].rounds, probe_rows[n].key, 1'b0);
            if (probe_rows[n].typed)
                want = {probe_rows[n].want_rw, probe_rows[n].want_lw};
            else
                want = tea_cipher_block(probe_rows[n].op, probe_rows[n].lw, probe_rows[n].rw);
            send_request(probe_rows[n].op, probe_rows[n].lw, probe_rows[n].rw, want);
        end

        // Random phases, each with its own setting and receiver pattern.
        for (int ph = 0; ph < 7; ph++) begin
            key = {$urandom, $urandom, $urandom, $urandom};
            case (ph)
                0: begin rounds = 8'd32;  count = 100; mode = RX_ALWAYS;  end
                1: begin rounds = 8'd0;   count = 80;  mode = RX_RANDOM;  key = KEY_ONES; end
                2: begin rounds = 8'd1;   count = 80;  mode = RX_PATTERN; end
                3: begin rounds = 8'd255; count = 6;   mode = RX_SPARSE;  end
                4: begin
                    rounds = 8'($urandom_range(2, 12));
                    count = 120;
                    mode = RX_RANDOM;
                end
                5: begin
                    rounds = 8'($urandom_range(0, 40));
                    count = 80;
                    mode = RX_PATTERN;
                    key = 128'h0;
                end
                default: begin
                    rounds = 8'd4;
                    count = 64;
                    mode = RX_SPARSE;
                    key[95:64] = 32'hffffffff;
                end
            endcase
            apply_setting(rounds, key, 1'b1);
            // Writes past the last register must leave every register alone.
            if (ph == 1)
                for (int ix = int'(REG_ROUNDS) + 1; ix < 8; ix++)
                    write_register(3'(ix), $urandom);
            rx_mode <= mode;
            if (ph == 0)
                hold_go = 1'b1;
            for (int k = 0; k < count; k++) begin
                if (have_last && $urandom_range(0, 3) == 0) begin
                    // Feed the previous result back the other way.
                    op = ~last_op;
                    lw = last_block[31:0];
                    rw = last_block[63:32];
                end else begin
                    op = 1'($urandom_range(0, 1));
                    lw = ($urandom_range(0, 7) == 0) ? {32{1'($urandom)}} : $urandom;
                    rw = ($urandom_range(0, 7) == 0) ? {32{1'($urandom)}} : $urandom;
                end
                want = tea_cipher_block(op, lw, rw);
                send_request(op, lw, rw, want);
                last_block = want;
                last_op = op;
                have_last = 1'b1;
            end
        end

        finish_pending();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests of both kinds under %0d register settings,",
            requests_sent, settings_applied);
        $display("cycle counts 0 to 255, with stalls on both channels; %0d results checked.",
            results_checked);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung unit.
    initial begin
        #8000000;
        $display("Timeout with %0d results still owed.", expected_blocks.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hdl/tea_pkg.sv
hdl/tea_regs.sv
hdl/tea_dp.sv
hdl/tea_ctrl.sv
hdl/tea_block_cipher_unit.sv
tb/tb_top.sv
